[design/ltgk_pkg.sv]
// ----------------------------------------------------------------------------
// ltgk_pkg
// Shared types, fixed-point constants and helpers of the track kinematics block.
// ----------------------------------------------------------------------------
package ltgk_pkg;

  localparam int CordicSteps = 30;
  localparam int IterStages  = 32;

  localparam logic signed [35:0] Q30Pi     = 36'sd3373259426;
  localparam logic signed [35:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [35:0] Q30TwoPi  = 36'sd6746518852;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [31:0] SnpOne     = 32'sd1073741824;
  localparam logic [30:0]        PtMax      = 31'h7FFF_FFFF;
  localparam logic [31:0]        PtClampMag = 32'd128;
  localparam logic [32:0]        DivInitRem = 33'd64;
  localparam logic [63:0]        SqrtOneQ60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0]        TglOneQ46  = 64'h0000_4000_0000_0000;

  localparam logic signed [31:0] AtanTab [CordicSteps] = '{
    32'sd843314856, 32'sd497837829, 32'sd263043836, 32'sd133525158, 32'sd67021686,
    32'sd33543515, 32'sd16775850, 32'sd8388437, 32'sd4194282, 32'sd2097149,
    32'sd1048575, 32'sd524287, 32'sd262143, 32'sd131071, 32'sd65535,
    32'sd32767, 32'sd16383, 32'sd8191, 32'sd4095, 32'sd2047,
    32'sd1023, 32'sd511, 32'sd255, 32'sd127, 32'sd63,
    32'sd31, 32'sd15, 32'sd7, 32'sd3, 32'sd1
  };

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StSat    = 2'd1,
    StZeroed = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] snp;
    logic signed [31:0] tgl;
    logic [31:0]        mag;
    logic signed [31:0] ang;
    logic               neg;
    logic               pt_clamp;
    logic               flag;
    logic               zero;
  } item_t;

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat_s32(input logic signed [39:0] v);
    sat_t r;
    r.ovf = 1'b0;
    r.val = v[31:0];
    if (v > 40'sd2147483647) begin
      r.ovf = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r.ovf = 1'b1;
      r.val = 32'sh8000_0000;
    end
    return r;
  endfunction

endpackage

[design/local_track_to_global_kinematics_top.sv]
// ----------------------------------------------------------------------------
// local_track_to_global_kinematics_top
// Converts local track parameters into global momentum and position.
// ----------------------------------------------------------------------------
// The input channel (in_valid_i / in_stall_o) carries one track item per
// unstalled cycle: local position, sine of azimuth, dip tangent, inverse
// momentum and frame angle. The output channel (out_valid_o / out_stall_i)
// returns one result item per track with momentum, position and a status
// code. The mode register is written through cfg_valid_i / cfg_ready_o with
// the bit on cfg_data_i; it is always ready and should change only when idle.
// Throughput is one item per cycle while out_stall_i is low. Each item
// passes the input register, the 32-stage rotator, reciprocal and root
// pipelines, then the product and saturation stages to the result.
// A queue of QueueDepth items decouples the input from the datapath. When
// the receiver stalls, the whole datapath holds, the queue fills and then
// in_stall_o rises. Reset clears the mode register, the queue and all
// valid flags; no item is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module local_track_to_global_kinematics_top import ltgk_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] x_local_i,
  input  logic signed [31:0] y_local_i,
  input  logic signed [31:0] z_local_i,
  input  logic signed [31:0] sin_phi_local_i,
  input  logic signed [31:0] tan_lambda_i,
  input  logic signed [31:0] inv_pt_i,
  input  logic signed [30:0] frame_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] mom_x_o,
  output logic signed [31:0] mom_y_o,
  output logic signed [31:0] mom_z_o,
  output logic [30:0]        mom_total_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic [1:0]         status_o
);

  item_t   front_item, head_item;
  logic    q_full, q_empty, q_pop;
  status_e status;

  ltgk_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .x_local_i       (x_local_i),
    .y_local_i       (y_local_i),
    .z_local_i       (z_local_i),
    .sin_phi_local_i (sin_phi_local_i),
    .tan_lambda_i    (tan_lambda_i),
    .inv_pt_i        (inv_pt_i),
    .frame_angle_i   (frame_angle_i),
    .item_o          (front_item)
  );

  ltgk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (head_item)
  );

  ltgk_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (head_item),
    .item_valid_i (!q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .mom_x_o      (mom_x_o),
    .mom_y_o      (mom_y_o),
    .mom_z_o      (mom_z_o),
    .mom_total_o  (mom_total_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .pos_z_o      (pos_z_o),
    .status_o     (status)
  );

  assign in_stall_o = q_full;
  assign status_o   = status;

endmodule

[design/ltgk_front.sv]
// ----------------------------------------------------------------------------
// ltgk_front
// Holds the mode register and classifies each incoming track item.
// ----------------------------------------------------------------------------
module ltgk_front import ltgk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i,
  input  logic signed [31:0] x_local_i,
  input  logic signed [31:0] y_local_i,
  input  logic signed [31:0] z_local_i,
  input  logic signed [31:0] sin_phi_local_i,
  input  logic signed [31:0] tan_lambda_i,
  input  logic signed [31:0] inv_pt_i,
  input  logic signed [30:0] frame_angle_i,
  output item_t              item_o
);

  logic zero_mode_q;

  logic signed [35:0] ang_raw, ang_wrap, ang_unw, ang_fold;
  logic               fold;
  logic [31:0]        mag;
  logic               snp_hi, snp_lo, pt_clamp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      zero_mode_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // The angle is wrapped once into [-pi, pi] and folded into [-pi/2, pi/2].
  always_comb begin
    ang_raw  = {{3{frame_angle_i[30]}}, frame_angle_i, 2'b00};
    ang_wrap = (ang_raw > Q30Pi) ? ang_raw - Q30TwoPi : ang_raw;
    ang_unw  = (ang_wrap < -Q30Pi) ? ang_wrap + Q30TwoPi : ang_wrap;
    fold     = 1'b0;
    ang_fold = ang_unw;
    if (ang_unw > Q30HalfPi) begin
      ang_fold = ang_unw - Q30Pi;
      fold     = 1'b1;
    end else if (ang_unw < -Q30HalfPi) begin
      ang_fold = ang_unw + Q30Pi;
      fold     = 1'b1;
    end
  end

  assign mag      = inv_pt_i[31] ? (~inv_pt_i + 32'd1) : inv_pt_i;
  assign snp_hi   = sin_phi_local_i > SnpOne;
  assign snp_lo   = sin_phi_local_i < -SnpOne;
  assign pt_clamp = mag <= PtClampMag;

  always_comb begin
    item_o.x        = x_local_i;
    item_o.y        = y_local_i;
    item_o.z        = z_local_i;
    item_o.snp      = snp_hi ? SnpOne : (snp_lo ? -SnpOne : sin_phi_local_i);
    item_o.tgl      = tan_lambda_i;
    item_o.mag      = mag;
    item_o.ang      = ang_fold[31:0];
    item_o.neg      = fold;
    item_o.pt_clamp = pt_clamp;
    item_o.flag     = snp_hi | snp_lo | pt_clamp;
    item_o.zero     = zero_mode_q && (x_local_i == 32'sd0);
  end

endmodule

[design/ltgk_queue.sv]
// ----------------------------------------------------------------------------
// ltgk_queue
// Short first-in first-out buffer between the classifier and the datapath.
// ----------------------------------------------------------------------------
module ltgk_queue import ltgk_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

[design/ltgk_isqrt.sv]
// ----------------------------------------------------------------------------
// ltgk_isqrt
// Pipelined floor square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module ltgk_isqrt import ltgk_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] n_i,
  output logic [31:0] root_o
);

  logic [63:0] n_q    [IterStages];
  logic [34:0] rem_q  [IterStages];
  logic [31:0] root_q [IterStages];

  for (genvar k = 0; k < IterStages; k++) begin : g_step
    logic [63:0] n_in;
    logic [34:0] rem_in, rem_t, trial;
    logic [31:0] root_in;

    if (k == 0) begin : g_first
      assign n_in    = n_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign n_in    = n_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_t = {rem_in[32:0], n_in[63:62]};
    assign trial = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= {n_in[61:0], 2'b00};
        if (rem_t >= trial) begin
          rem_q[k]  <= rem_t - trial;
          root_q[k] <= {root_in[30:0], 1'b1};
        end else begin
          rem_q[k]  <= rem_t;
          root_q[k] <= {root_in[30:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[IterStages-1];

endmodule

[design/ltgk_back.sv]
// ----------------------------------------------------------------------------
// ltgk_back
// Datapath: rotator, reciprocal, roots, products and saturation per item.
// ----------------------------------------------------------------------------
module ltgk_back import ltgk_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              item_i,
  input  logic               item_valid_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] mom_x_o,
  output logic signed [31:0] mom_y_o,
  output logic signed [31:0] mom_z_o,
  output logic [30:0]        mom_total_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output status_e            status_o
);

  localparam int Last = IterStages - 1;

  logic en;

  logic        b0_valid_q;
  item_t       b0_item_q;
  logic [63:0] n1_q, n2_q;
  logic signed [63:0] snp_sq, tgl_sq;

  logic              it_valid_q [IterStages];
  item_t             sc_q       [IterStages];
  logic signed [33:0] cx_q      [IterStages];
  logic signed [33:0] cy_q      [IterStages];
  logic signed [33:0] cz_q      [IterStages];
  logic [32:0]       dr_q       [IterStages];
  logic [31:0]       dq_q       [IterStages];
  logic [31:0]       dm_q       [IterStages];
  logic [31:0]       root1, root2;

  logic [3:0]         m_valid_q;
  item_t              m0_item_q;
  logic signed [33:0] m0_ca_q, m0_sa_q;
  logic signed [32:0] m0_cs_q;
  logic [30:0]        m0_pt_q;
  logic [31:0]        m0_rt_q;

  logic signed [66:0] p_cc_q, p_ss_q, p_sc_q, p_cs_q;
  logic signed [66:0] p_xc_q, p_ys_q, p_xs_q, p_yc_q;
  logic signed [63:0] p_pz_q;
  logic [62:0]        p_pt_q;
  logic [30:0]        m1_pt_q;
  logic signed [31:0] m1_z_q;
  logic               m1_flag_q, m1_zero_q;

  logic signed [66:0] sum_c, sum_s, sum_px, sum_py;
  sat_t               sat_px, sat_py, sat_pz;
  logic               mt_ovf;
  logic signed [33:0] m2_cphi_q, m2_sphi_q;
  logic signed [31:0] m2_px_q, m2_py_q, m2_pz_q, m2_z_q;
  logic [30:0]        m2_mt_q, m2_pt_q;
  logic               m2_flag_q, m2_zero_q;

  logic signed [65:0] p_mx_q, p_my_q;
  logic signed [31:0] m3_px_q, m3_py_q, m3_pz_q, m3_z_q;
  logic [30:0]        m3_mt_q;
  logic               m3_flag_q, m3_zero_q;

  sat_t sat_mx, sat_my;

  logic out_valid_q;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && item_valid_i;

  assign snp_sq = $signed(item_i.snp) * $signed(item_i.snp);
  assign tgl_sq = $signed(item_i.tgl) * $signed(item_i.tgl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_valid_q  <= 1'b0;
      m_valid_q   <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b0_valid_q  <= item_valid_i;
      m_valid_q   <= {m_valid_q[2:0], it_valid_q[Last]};
      out_valid_q <= m_valid_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b0_item_q <= item_i;
      n1_q      <= SqrtOneQ60 - $unsigned(snp_sq);
      n2_q      <= $unsigned(tgl_sq) + TglOneQ46;
    end
  end

  for (genvar k = 0; k < IterStages; k++) begin : g_iter
    logic signed [33:0] cx_in, cy_in, cz_in;
    logic [32:0]        dr_in, dr_sh;
    logic [31:0]        dq_in, dm_in;
    item_t              sc_in;
    logic               v_in;

    if (k == 0) begin : g_first
      assign cx_in = CordicGain;
      assign cy_in = '0;
      assign cz_in = {{2{b0_item_q.ang[31]}}, b0_item_q.ang};
      assign dr_in = DivInitRem;
      assign dq_in = '0;
      assign dm_in = b0_item_q.mag;
      assign sc_in = b0_item_q;
      assign v_in  = b0_valid_q;
    end else begin : g_next
      assign cx_in = cx_q[k-1];
      assign cy_in = cy_q[k-1];
      assign cz_in = cz_q[k-1];
      assign dr_in = dr_q[k-1];
      assign dq_in = dq_q[k-1];
      assign dm_in = dm_q[k-1];
      assign sc_in = sc_q[k-1];
      assign v_in  = it_valid_q[k-1];
    end

    assign dr_sh = {dr_in[31:0], 1'b0};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        it_valid_q[k] <= 1'b0;
      end else if (en) begin
        it_valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sc_q[k] <= sc_in;
        dm_q[k] <= dm_in;
        if (dr_sh >= {1'b0, dm_in}) begin
          dr_q[k] <= dr_sh - {1'b0, dm_in};
          dq_q[k] <= {dq_in[30:0], 1'b1};
        end else begin
          dr_q[k] <= dr_sh;
          dq_q[k] <= {dq_in[30:0], 1'b0};
        end
      end
    end

    if (k < CordicSteps) begin : g_rot
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (cz_in >= 0) begin
            cx_q[k] <= cx_in - (cy_in >>> k);
            cy_q[k] <= cy_in + (cx_in >>> k);
            cz_q[k] <= cz_in - 34'(AtanTab[k]);
          end else begin
            cx_q[k] <= cx_in + (cy_in >>> k);
            cy_q[k] <= cy_in - (cx_in >>> k);
            cz_q[k] <= cz_in + 34'(AtanTab[k]);
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk_i) begin
        if (en) begin
          cx_q[k] <= cx_in;
          cy_q[k] <= cy_in;
          cz_q[k] <= cz_in;
        end
      end
    end
  end

  ltgk_isqrt u_sqrt_cos (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (n1_q),
    .root_o (root1)
  );

  ltgk_isqrt u_sqrt_dip (
    .clk_i  (clk_i),
    .en_i   (en),
    .n_i    (n2_q),
    .root_o (root2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      m0_item_q <= sc_q[Last];
      m0_ca_q   <= sc_q[Last].neg ? -cx_q[Last] : cx_q[Last];
      m0_sa_q   <= sc_q[Last].neg ? -cy_q[Last] : cy_q[Last];
      m0_cs_q   <= $signed({1'b0, root1});
      m0_pt_q   <= sc_q[Last].pt_clamp ? PtMax : dq_q[Last][30:0];
      m0_rt_q   <= root2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_cc_q    <= m0_cs_q * m0_ca_q;
      p_ss_q    <= $signed(m0_item_q.snp) * m0_sa_q;
      p_sc_q    <= $signed(m0_item_q.snp) * m0_ca_q;
      p_cs_q    <= m0_cs_q * m0_sa_q;
      p_xc_q    <= $signed(m0_item_q.x) * m0_ca_q;
      p_ys_q    <= $signed(m0_item_q.y) * m0_sa_q;
      p_xs_q    <= $signed(m0_item_q.x) * m0_sa_q;
      p_yc_q    <= $signed(m0_item_q.y) * m0_ca_q;
      p_pz_q    <= $signed({1'b0, m0_pt_q}) * $signed(m0_item_q.tgl);
      p_pt_q    <= m0_pt_q * m0_rt_q;
      m1_pt_q   <= m0_pt_q;
      m1_z_q    <= m0_item_q.z;
      m1_flag_q <= m0_item_q.flag;
      m1_zero_q <= m0_item_q.zero;
    end
  end

  assign sum_c  = p_cc_q - p_ss_q;
  assign sum_s  = p_sc_q + p_cs_q;
  assign sum_px = p_xc_q - p_ys_q;
  assign sum_py = p_xs_q + p_yc_q;
  assign sat_px = sat_s32($signed(sum_px[66:30]));
  assign sat_py = sat_s32($signed(sum_py[66:30]));
  assign sat_pz = sat_s32($signed(p_pz_q[62:23]));
  assign mt_ovf = |p_pt_q[62:54];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_cphi_q <= sum_c[63:30];
      m2_sphi_q <= sum_s[63:30];
      m2_px_q   <= sat_px.val;
      m2_py_q   <= sat_py.val;
      m2_pz_q   <= sat_pz.val;
      m2_mt_q   <= mt_ovf ? PtMax : p_pt_q[53:23];
      m2_pt_q   <= m1_pt_q;
      m2_z_q    <= m1_z_q;
      m2_flag_q <= m1_flag_q | sat_px.ovf | sat_py.ovf | sat_pz.ovf | mt_ovf;
      m2_zero_q <= m1_zero_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_mx_q    <= $signed({1'b0, m2_pt_q}) * m2_cphi_q;
      p_my_q    <= $signed({1'b0, m2_pt_q}) * m2_sphi_q;
      m3_px_q   <= m2_px_q;
      m3_py_q   <= m2_py_q;
      m3_pz_q   <= m2_pz_q;
      m3_mt_q   <= m2_mt_q;
      m3_z_q    <= m2_z_q;
      m3_flag_q <= m2_flag_q;
      m3_zero_q <= m2_zero_q;
    end
  end

  assign sat_mx = sat_s32($signed(p_mx_q[65:30]));
  assign sat_my = sat_s32($signed(p_my_q[65:30]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (m3_zero_q) begin
        mom_x_o     <= '0;
        mom_y_o     <= '0;
        mom_z_o     <= '0;
        mom_total_o <= '0;
        pos_x_o     <= '0;
        pos_y_o     <= '0;
        pos_z_o     <= '0;
        status_o    <= StZeroed;
      end else begin
        mom_x_o     <= sat_mx.val;
        mom_y_o     <= sat_my.val;
        mom_z_o     <= m3_pz_q;
        mom_total_o <= m3_mt_q;
        pos_x_o     <= m3_px_q;
        pos_y_o     <= m3_py_q;
        pos_z_o     <= m3_z_q;
        status_o    <= (m3_flag_q | sat_mx.ovf | sat_my.ovf) ? StSat : StOk;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/ltgk_checker.sv]
// ----------------------------------------------------------------------------
// ltgk_checker
// Port-level checks of the track kinematics block, bound to its top level.
// ----------------------------------------------------------------------------
module ltgk_checker import ltgk_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] mom_x_o,
  input logic signed [31:0] mom_y_o,
  input logic signed [31:0] mom_z_o,
  input logic [30:0]        mom_total_o,
  input logic signed [31:0] pos_x_o,
  input logic signed [31:0] pos_y_o,
  input logic signed [31:0] pos_z_o,
  input logic [1:0]         status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mom_x_o) && $stable(mom_total_o)
      && $stable(pos_x_o) && $stable(status_o))
    else $error("Result item changed while stalled.");

  a_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StZeroed |-> mom_x_o == 32'sd0 && mom_y_o == 32'sd0
      && mom_z_o == 32'sd0 && mom_total_o == 31'd0 && pos_x_o == 32'sd0
      && pos_y_o == 32'sd0 && pos_z_o == 32'sd0)
    else $error("Zeroed item carries nonzero fields.");

  a_total_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StOk |-> mom_total_o >= 31'd128)
    else $error("Total momentum below the smallest reachable value.");

endmodule

bind local_track_to_global_kinematics_top ltgk_checker u_ltgk_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the track kinematics block against a bit-exact fixed-point predictor.
// Directed tracks cover field extremes, the zero mode, a zero or tiny inverse
// momentum, a sine beyond unity and angles past pi. Random tracks follow with
// random idling on both channels. Results are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ltgk_pkg::*;

  typedef struct {
    logic signed [31:0] x, y, z, snp, tgl, ipt;
    logic signed [30:0] ang;
  } track_t;

  typedef struct {
    logic signed [31:0] px, py, pz;
    logic [30:0]        p;
    logic signed [31:0] gx, gy, gz;
    logic [1:0]         st;
  } kin_t;

  class kin_scoreboard;
    kin_t   pending[$];
    bit     zero_mode;
    int     errors;

    function longint floor_shr(longint v, int s);
      return v >>> s;
    endfunction

    function longint clip32(longint v, ref bit f);
      if (v > 64'sd2147483647) begin
        f = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        f = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void rotate(longint a, output longint c, output longint s);
      longint rx, ry, rz, dx, dy;
      bit neg;
      neg = 0;
      rx = 652032874;
      ry = 0;
      if (a > 64'sd3373259426) a -= 64'sd6746518852;
      if (a < -64'sd3373259426) a += 64'sd6746518852;
      if (a > 64'sd1686629713) begin
        a -= 64'sd3373259426;
        neg = 1;
      end else if (a < -64'sd1686629713) begin
        a += 64'sd3373259426;
        neg = 1;
      end
      rz = a;
      for (int i = 0; i < 30; i++) begin
        dx = ry >>> i;
        dy = rx >>> i;
        if (rz >= 0) begin
          rx -= dx;
          ry += dy;
          rz -= longint'(AtanTab[i]);
        end else begin
          rx += dx;
          ry -= dy;
          rz += longint'(AtanTab[i]);
        end
      end
      c = neg ? -rx : rx;
      s = neg ? -ry : ry;
    endfunction

    function void note_track(track_t t);
      kin_t k;
      longint x, y, snp, tgl, ipt, ca, sa, cs, cp, sp, pt, pp;
      longint unsigned mag, q, root;
      bit f;
      f = 0;
      x = t.x;
      y = t.y;
      snp = t.snp;
      tgl = t.tgl;
      ipt = t.ipt;
      if (zero_mode && x == 0) begin
        k = '{default: 0};
        k.st = StZeroed;
        pending.push_back(k);
        return;
      end
      rotate(longint'(t.ang) * 4, ca, sa);
      if (snp > 64'sd1073741824) begin
        snp = 64'sd1073741824;
        f = 1;
      end
      if (snp < -64'sd1073741824) begin
        snp = -64'sd1073741824;
        f = 1;
      end
      cs = int_sqrt(64'd1152921504606846976 - snp * snp);
      cp = (cs * ca - snp * sa) >>> 30;
      sp = (snp * ca + cs * sa) >>> 30;
      mag = (ipt < 0) ? -ipt : ipt;
      if (mag == 0) begin
        pt = 64'h7FFFFFFF;
        f = 1;
      end else begin
        q = (64'd1 << 38) / mag;
        if (q > 64'h7FFFFFFF) begin
          pt = 64'h7FFFFFFF;
          f = 1;
        end else begin
          pt = q;
        end
      end
      k.px = clip32((pt * cp) >>> 30, f);
      k.py = clip32((pt * sp) >>> 30, f);
      k.pz = clip32((pt * tgl) >>> 23, f);
      root = int_sqrt(longint'(tgl * tgl) + (64'd1 << 46));
      pp = (pt * longint'(root)) >>> 23;
      if (pp > 64'sh7FFFFFFF) begin
        pp = 64'sh7FFFFFFF;
        f = 1;
      end
      k.p = pp;
      k.gx = clip32((x * ca - y * sa) >>> 30, f);
      k.gy = clip32((x * sa + y * ca) >>> 30, f);
      k.gz = t.z;
      k.st = f ? StSat : StOk;
      pending.push_back(k);
    endfunction

    function void check_result(kin_t a);
      kin_t e;
      if (pending.size() == 0) begin
        $error("Unexpected result item");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.px !== e.px) begin $error("mom_x exp %0d got %0d", e.px, a.px); errors++; end
      if (a.py !== e.py) begin $error("mom_y exp %0d got %0d", e.py, a.py); errors++; end
      if (a.pz !== e.pz) begin $error("mom_z exp %0d got %0d", e.pz, a.pz); errors++; end
      if (a.p !== e.p) begin $error("mom_total exp %0d got %0d", e.p, a.p); errors++; end
      if (a.gx !== e.gx) begin $error("pos_x exp %0d got %0d", e.gx, a.gx); errors++; end
      if (a.gy !== e.gy) begin $error("pos_y exp %0d got %0d", e.gy, a.gy); errors++; end
      if (a.gz !== e.gz) begin $error("pos_z exp %0d got %0d", e.gz, a.gz); errors++; end
      if (a.st !== e.st) begin $error("status exp %0d got %0d", e.st, a.st); errors++; end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o, cfg_data_i;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic signed [31:0] x_local_i, y_local_i, z_local_i, sin_phi_local_i;
  logic signed [31:0] tan_lambda_i, inv_pt_i;
  logic signed [30:0] frame_angle_i;
  logic signed [31:0] mom_x_o, mom_y_o, mom_z_o, pos_x_o, pos_y_o, pos_z_o;
  logic [30:0] mom_total_o;
  logic [1:0] status_o;

  kin_scoreboard tracks = new();
  bit calm;
  int idle_cycles;

  local_track_to_global_kinematics_top i_dut (.*);

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      tracks.note_track('{x_local_i, y_local_i, z_local_i, sin_phi_local_i,
                          tan_lambda_i, inv_pt_i, frame_angle_i});
    end
    if (out_valid_o && !out_stall_i) begin
      tracks.check_result('{mom_x_o, mom_y_o, mom_z_o, mom_total_o,
                            pos_x_o, pos_y_o, pos_z_o, status_o});
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 35);
  end

  always @(posedge clk_i) begin
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_mode(bit v);
    cfg_valid_i <= 1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    tracks.zero_mode = v;
  endtask

  task automatic send_track(track_t t);
    while (!calm && $urandom_range(99) < 35) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1;
    x_local_i       <= t.x;
    y_local_i       <= t.y;
    z_local_i       <= t.z;
    sin_phi_local_i <= t.snp;
    tan_lambda_i    <= t.tgl;
    inv_pt_i        <= t.ipt;
    frame_angle_i   <= t.ang;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (tracks.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic track_t random_track();
    track_t t;
    t.x = $urandom();
    t.y = $urandom();
    t.z = $urandom();
    t.tgl = $urandom();
    t.ipt = $urandom();
    t.snp = $signed($urandom_range(2147483647)) - 32'sd1073741824;
    t.ang = $signed($urandom_range(1686629714)) - 31'sd843314857;
    case ($urandom_range(7))
      0: t.x = 0;
      1: t.ipt = $signed($urandom_range(400)) - 200;
      2: begin
        t.x = $signed(32'($urandom_range(65535))) - 32768;
        t.y = $signed(32'($urandom_range(65535))) - 32768;
        t.tgl = $signed(32'($urandom_range(1 << 25))) - (1 << 24);
        t.ipt = $signed(32'($urandom_range(1 << 25))) - (1 << 24);
      end
      3: t.ang = $urandom();
      4: t.snp = $urandom();
      default: ;
    endcase
    return t;
  endfunction

  initial begin
    track_t t;
    cfg_valid_i = 0; cfg_data_i = 0; in_valid_i = 0; out_stall_i = 0;
    x_local_i = 0; y_local_i = 0; z_local_i = 0; sin_phi_local_i = 0;
    tan_lambda_i = 0; inv_pt_i = 0; frame_angle_i = 0;
    calm = 0; idle_cycles = 0;
    rst_ni = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    write_mode(1);
    send_track('{0, 5, 7, 0, 0, 1 << 23, 0});
    send_track('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd1073741824,
                 32'sh7FFFFFFF, 32'sh7FFFFFFF, 31'sd843314857});
    send_track('{32'sh80000000, 32'sh80000000, 32'sh80000000, -32'sd1073741824,
                 32'sh80000000, 32'sh80000000, -31'sd843314857});
    send_track('{4096, 4096, 4096, 0, 0, 0, 0});
    send_track('{4096, -4096, 0, 32'sh7FFFFFFF, 1 << 23, 1, 31'sh3FFFFFFF});
    send_track('{4096, 0, 0, 32'sh80000000, -(1 << 23), -128, 31'sh40000000});
    send_track('{4096, 4096, 0, 1 << 29, 1 << 23, 129, 31'sd500000000});
    send_track('{-1, -1, -1, -1, -1, -1, -1});
    drain();
    write_mode(0);
    send_track('{0, 5, 7, 0, 0, 1 << 23, 0});
    send_track('{0, 0, 0, 0, 0, 0, 0});
    for (int i = 0; i < 1250; i++) begin
      if (i == 300) calm = 1;
      if (i == 500) calm = 0;
      if (i == 600) begin
        drain();
        write_mode(1);
      end
      if (i == 1000) begin
        drain();
        write_mode(0);
      end
      t = random_track();
      send_track(t);
    end
    drain();
    if (tracks.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[local_track_to_global_kinematics_top.f]
design/ltgk_pkg.sv
design/ltgk_front.sv
design/ltgk_queue.sv
design/ltgk_isqrt.sv
design/ltgk_back.sv
design/local_track_to_global_kinematics_top.sv
design/ltgk_checker.sv
test/tb_top.sv
